/* rtl/core/indexed_object_stack_core_defines.svh */
// assertion macros for the indexed object stack core
`ifndef INDEXED_OBJECT_STACK_CORE_DEFINES_SVH
`define INDEXED_OBJECT_STACK_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define IOS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ios assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define IOS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ios assertion failed");

`endif

/* rtl/core/ios_pkg.sv */
// shared types and codes for the indexed object stack core
package ios_pkg;

  localparam int TYPE_BITS  = 5;
  localparam int VALUE_BITS = 64;
  localparam int POS_BITS   = 8;
  localparam int DEPTH_BITS = 9;
  localparam int STAT_BITS  = 3;
  localparam int CMD_BITS   = 3;
  localparam int ENTRY_BITS = TYPE_BITS + VALUE_BITS;

  localparam logic [CMD_BITS-1:0] CMD_PUSH     = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_POP      = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_FETCH_TD = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_REPL_TD  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_FETCH_BU = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_REPL_BU  = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_FIND     = 3'd6;

  localparam logic [STAT_BITS-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_RANGE    = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_INVALID  = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [STAT_BITS-1:0]  status;
    logic [TYPE_BITS-1:0]  rtype;
    logic [VALUE_BITS-1:0] rvalue;
    logic [POS_BITS-1:0]   fpos;
  } res_t;

endpackage

/* rtl/core/indexed_object_stack_core.sv */
// indexed object stack core: top level with request and result channels
//
// Each request on the in_ stream carries one command: push, pop, fetch or
// replace at a position counted from the top or bottom, or a search for a
// type tag; in_tuser high empties the stack instead. Every request gives
// exactly one result on the out_ stream with status, object and depth.
// Requests are handled one at a time; in_tready is high only while idle.
// Clear, push, replace and refused commands finish without a store read;
// pop and fetch wait on the registered store read. A type search walks
// the store one entry a cycle through the single read port. The result is
// registered in the output register, which drives out_tvalid.
// When the receiver stalls, the result stays in the output register and
// the next result waits in the sequencer, which then takes no request.
// Reset empties the stack and drops any pending result; store contents are
// not cleared and are never read before being pushed.
module indexed_object_stack_core #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], position[10:3], object_type[15:11], object_value[79:16]
  input  logic [79:0] in_tdata,
  // clear_all[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], result_type[7:3], result_value[71:8], found_position[79:72],
  // current_depth[88:80], zero[95:89]
  output logic [95:0] out_tdata
);

  localparam int CW = $clog2(DEPTH + 1);

  ios_pkg::res_t                        res;
  logic                                 res_valid;
  logic                                 res_ready;
  logic [CW-1:0]                        fill;
  logic                                 mem_we;
  logic [$clog2(DEPTH)-1:0]             mem_waddr;
  logic [ios_pkg::ENTRY_BITS-1:0]       mem_wdata;
  logic [$clog2(DEPTH)-1:0]             mem_raddr;
  logic [ios_pkg::ENTRY_BITS-1:0]       mem_rdata;

  logic                                 out_valid_r;
  ios_pkg::res_t                        out_res_r;
  logic [ios_pkg::DEPTH_BITS-1:0]       out_depth_r;

  ios_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tdata[2:0]),
    .pos       (in_tdata[10:3]),
    .typ       (in_tdata[15:11]),
    .val       (in_tdata[79:16]),
    .clr       (in_tuser),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .fill      (fill),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ios_store #(
    .DEPTH(DEPTH),
    .WIDTH(ios_pkg::ENTRY_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res_r   <= res;
      out_depth_r <= ios_pkg::DEPTH_BITS'(fill);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_depth_r, out_res_r.fpos, out_res_r.rvalue,
                       out_res_r.rtype, out_res_r.status};

`include "indexed_object_stack_core_defines.svh"

  `IOS_ASSERT_NXT(a_one_request, in_tvalid && in_tready, !in_tready)
  `IOS_ASSERT_IMP(a_fill_bound, 1'b1, fill <= CW'(DEPTH))
  `IOS_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

endmodule

/* rtl/core/ios_store.sv */
// entry store: one write port, one registered read port
module ios_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 69
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/ios_ctrl.sv */
// command sequencer with shared address unit and fill counter
module ios_ctrl #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ios_pkg::CMD_BITS-1:0]        cmd,
  input  logic [ios_pkg::POS_BITS-1:0]        pos,
  input  logic [ios_pkg::TYPE_BITS-1:0]       typ,
  input  logic [ios_pkg::VALUE_BITS-1:0]      val,
  input  logic                                clr,
  output ios_pkg::res_t                       res,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [$clog2(DEPTH+1)-1:0]          fill,
  output logic                                mem_we,
  output logic [$clog2(DEPTH)-1:0]            mem_waddr,
  output logic [ios_pkg::ENTRY_BITS-1:0]      mem_wdata,
  output logic [$clog2(DEPTH)-1:0]            mem_raddr,
  input  logic [ios_pkg::ENTRY_BITS-1:0]      mem_rdata
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > ios_pkg::POS_BITS) ? CW : ios_pkg::POS_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [ios_pkg::CMD_BITS-1:0]    cmd_r, cmd_nxt;
  logic [ios_pkg::POS_BITS-1:0]    pos_r, pos_nxt;
  logic [ios_pkg::TYPE_BITS-1:0]   typ_r, typ_nxt;
  logic [ios_pkg::VALUE_BITS-1:0]  val_r, val_nxt;
  logic                            clr_r, clr_nxt;
  logic [CW-1:0]                   fill_r, fill_nxt;
  logic [AW-1:0]                   addr_r, addr_nxt;
  logic [CW-1:0]                   k_r, k_nxt;
  ios_pkg::res_t                   res_r, res_nxt;

  logic [CMPW-1:0]                 au_a, au_b, au_sum;
  logic [CMPW-1:0]                 pos_ext, fill_ext;
  logic                            top_down;
  logic [ios_pkg::TYPE_BITS-1:0]   rd_type;
  logic [ios_pkg::VALUE_BITS-1:0]  rd_value;

  assign pos_ext  = CMPW'(pos_r);
  assign fill_ext = CMPW'(fill_r);
  assign top_down = (cmd_r == ios_pkg::CMD_FETCH_TD) || (cmd_r == ios_pkg::CMD_REPL_TD);
  assign rd_type  = mem_rdata[ios_pkg::ENTRY_BITS-1 -: ios_pkg::TYPE_BITS];
  assign rd_value = mem_rdata[ios_pkg::VALUE_BITS-1:0];

  // shared address unit: a - b - 1
  always_comb begin
    au_a = '0;
    au_b = '0;
    case (state_r)
      S_EXEC: begin
        au_a = fill_ext;
        au_b = top_down ? pos_ext : '0;
      end
      S_SRCH: begin
        au_a = CMPW'(addr_r);
        au_b = '0;
      end
      default: begin
        au_a = '0;
        au_b = '0;
      end
    endcase
  end

  assign au_sum = au_a + ~au_b;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    pos_nxt   = pos_r;
    typ_nxt   = typ_r;
    val_nxt   = val_r;
    clr_nxt   = clr_r;
    fill_nxt  = fill_r;
    addr_nxt  = addr_r;
    k_nxt     = k_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = {typ_r, val_r};
    mem_raddr = addr_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd;
          pos_nxt   = pos;
          typ_nxt   = typ;
          val_nxt   = val;
          clr_nxt   = clr;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        if (clr_r) begin
          fill_nxt = '0;
        end else begin
          case (cmd_r)
            ios_pkg::CMD_PUSH: begin
              if (typ_r == '0) begin
                res_nxt.status = ios_pkg::ST_INVALID;
              end else if (fill_r == CW'(DEPTH)) begin
                res_nxt.status = ios_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = fill_r[AW-1:0];
                fill_nxt  = fill_r + 1'b1;
              end
            end
            ios_pkg::CMD_POP: begin
              if (fill_r == '0) begin
                res_nxt.status = ios_pkg::ST_RANGE;
              end else begin
                mem_raddr = au_sum[AW-1:0];
                fill_nxt  = fill_r - 1'b1;
                state_nxt = S_RD;
              end
            end
            ios_pkg::CMD_FETCH_TD, ios_pkg::CMD_FETCH_BU: begin
              if (pos_ext >= fill_ext) begin
                res_nxt.status = ios_pkg::ST_RANGE;
              end else begin
                mem_raddr = top_down ? au_sum[AW-1:0] : pos_ext[AW-1:0];
                state_nxt = S_RD;
              end
            end
            ios_pkg::CMD_REPL_TD, ios_pkg::CMD_REPL_BU: begin
              if (pos_ext >= fill_ext) begin
                res_nxt.status = ios_pkg::ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = top_down ? au_sum[AW-1:0] : pos_ext[AW-1:0];
              end
            end
            ios_pkg::CMD_FIND: begin
              if (fill_r == '0) begin
                res_nxt.status = ios_pkg::ST_NOTFOUND;
              end else begin
                mem_raddr = au_sum[AW-1:0];
                addr_nxt  = au_sum[AW-1:0];
                k_nxt     = '0;
                state_nxt = S_SRCH;
              end
            end
            default: begin
              res_nxt.status = ios_pkg::ST_OK;
            end
          endcase
        end
      end
      S_RD: begin
        res_nxt.status = ios_pkg::ST_OK;
        res_nxt.rtype  = rd_type;
        res_nxt.rvalue = rd_value;
        res_nxt.fpos   = '0;
        state_nxt      = S_DONE;
      end
      S_SRCH: begin
        if (rd_type == typ_r) begin
          res_nxt.status = ios_pkg::ST_OK;
          res_nxt.rtype  = rd_type;
          res_nxt.rvalue = rd_value;
          res_nxt.fpos   = ios_pkg::POS_BITS'(k_r);
          state_nxt      = S_DONE;
        end else if ((k_r + 1'b1) == fill_r) begin
          res_nxt   = '0;
          res_nxt.status = ios_pkg::ST_NOTFOUND;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = au_sum[AW-1:0];
          addr_nxt  = au_sum[AW-1:0];
          k_nxt     = k_r + 1'b1;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
    cmd_r  <= cmd_nxt;
    pos_r  <= pos_nxt;
    typ_r  <= typ_nxt;
    val_r  <= val_nxt;
    clr_r  <= clr_nxt;
    addr_r <= addr_nxt;
    k_r    <= k_nxt;
    res_r  <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;
  assign fill      = fill_r;

endmodule

/* tb/tb_indexed_object_stack_core.sv */
// self-checking testbench for the indexed object stack core, with a local stack predictor
module tb_indexed_object_stack_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STACK_DEPTH  = 256;
  localparam int          RANDOM_ITEMS = 1150;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  localparam logic [ios_pkg::CMD_BITS-1:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic [ios_pkg::CMD_BITS-1:0]   cmd;
    logic [ios_pkg::POS_BITS-1:0]   pos;
    logic [ios_pkg::TYPE_BITS-1:0]  tag;
    logic [ios_pkg::VALUE_BITS-1:0] value;
    logic                           clr;
  } stack_req_t;

  typedef struct packed {
    logic [ios_pkg::STAT_BITS-1:0]  status;
    logic [ios_pkg::TYPE_BITS-1:0]  rtype;
    logic [ios_pkg::VALUE_BITS-1:0] rvalue;
    logic [ios_pkg::POS_BITS-1:0]   fpos;
    logic [ios_pkg::DEPTH_BITS-1:0] depth;
  } stack_reply_t;

  typedef struct packed {
    logic [ios_pkg::CMD_BITS-1:0]   cmd;
    logic [ios_pkg::POS_BITS-1:0]   pos;
    logic [ios_pkg::TYPE_BITS-1:0]  tag;
    logic [ios_pkg::VALUE_BITS-1:0] value;
    logic                           clr;
    logic                           typed;
    logic [ios_pkg::STAT_BITS-1:0]  status;
    logic [ios_pkg::DEPTH_BITS-1:0] depth;
  } table_row_t;

  // typed rows carry status and depth, object fields are zero
  localparam table_row_t DIRECTED_ROWS [23] = '{
    '{ios_pkg::CMD_POP, 8'd0, 5'd0, 64'd0,
      1'b0, 1'b1, ios_pkg::ST_RANGE, 9'd0},
    '{ios_pkg::CMD_FETCH_TD, 8'd0, 5'd0, 64'd0,
      1'b0, 1'b1, ios_pkg::ST_RANGE, 9'd0},
    '{ios_pkg::CMD_REPL_BU, 8'd0, 5'd3, 64'h1111_2222_3333_4444,
      1'b0, 1'b1, ios_pkg::ST_RANGE, 9'd0},
    '{ios_pkg::CMD_FIND, 8'd0, 5'd1, 64'd0,
      1'b0, 1'b1, ios_pkg::ST_NOTFOUND, 9'd0},
    '{ios_pkg::CMD_PUSH, 8'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF,
      1'b0, 1'b1, ios_pkg::ST_INVALID, 9'd0},
    '{ios_pkg::CMD_PUSH, 8'd255, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF,
      1'b0, 1'b1, ios_pkg::ST_OK, 9'd1},
    '{ios_pkg::CMD_PUSH, 8'd0, 5'd1, 64'd0,
      1'b0, 1'b1, ios_pkg::ST_OK, 9'd2},
    '{ios_pkg::CMD_PUSH, 8'd0, 5'd5, 64'h0123_4567_89AB_CDEF,
      1'b0, 1'b1, ios_pkg::ST_OK, 9'd3},
    '{ios_pkg::CMD_FETCH_TD, 8'd0, 5'd0, 64'd0,
      1'b0, 1'b0, ios_pkg::ST_OK, 9'd0},
    '{ios_pkg::CMD_FETCH_BU, 8'd0, 5'd0, 64'd0,
      1'b0, 1'b0, ios_pkg::ST_OK, 9'd0},
    '{ios_pkg::CMD_FETCH_TD, 8'd255, 5'd0, 64'd0,
      1'b0, 1'b1, ios_pkg::ST_RANGE, 9'd3},
    '{ios_pkg::CMD_FETCH_BU, 8'd3, 5'd0, 64'd0,
      1'b0, 1'b1, ios_pkg::ST_RANGE, 9'd3},
    '{ios_pkg::CMD_REPL_TD, 8'd1, 5'd0, 64'hA5A5_A5A5_A5A5_A5A5,
      1'b0, 1'b0, ios_pkg::ST_OK, 9'd0},
    '{ios_pkg::CMD_FIND, 8'd0, 5'd0, 64'd0,
      1'b0, 1'b0, ios_pkg::ST_OK, 9'd0},
    '{ios_pkg::CMD_REPL_BU, 8'd0, 5'd7, 64'h5A5A_5A5A_5A5A_5A5A,
      1'b0, 1'b0, ios_pkg::ST_OK, 9'd0},
    '{ios_pkg::CMD_FIND, 8'd0, 5'd7, 64'd0,
      1'b0, 1'b0, ios_pkg::ST_OK, 9'd0},
    '{ios_pkg::CMD_FIND, 8'd0, 5'd30, 64'd0,
      1'b0, 1'b1, ios_pkg::ST_NOTFOUND, 9'd3},
    '{ios_pkg::CMD_REPL_TD, 8'd255, 5'd9, 64'd1,
      1'b0, 1'b1, ios_pkg::ST_RANGE, 9'd3},
    '{CMD_UNUSED, 8'd17, 5'd12, 64'd5,
      1'b0, 1'b1, ios_pkg::ST_OK, 9'd3},
    '{ios_pkg::CMD_POP, 8'd0, 5'd0, 64'd0,
      1'b0, 1'b0, ios_pkg::ST_OK, 9'd0},
    '{ios_pkg::CMD_PUSH, 8'd0, 5'd4, 64'd9,
      1'b1, 1'b1, ios_pkg::ST_OK, 9'd0},
    '{ios_pkg::CMD_POP, 8'd0, 5'd0, 64'd0,
      1'b0, 1'b1, ios_pkg::ST_RANGE, 9'd0},
    '{ios_pkg::CMD_FETCH_BU, 8'd128, 5'd0, 64'd0,
      1'b0, 1'b1, ios_pkg::ST_RANGE, 9'd0}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  logic [ios_pkg::TYPE_BITS-1:0]  stack_tag [STACK_DEPTH];
  logic [ios_pkg::VALUE_BITS-1:0] stack_val [STACK_DEPTH];
  int unsigned                    stack_fill = 0;

  stack_reply_t pending_replies [$];
  int unsigned  mismatch_count = 0;
  int unsigned  replies_seen   = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  burst_left     = 0;

  indexed_object_stack_core #(.DEPTH(STACK_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic stack_req_t make_req(input logic [ios_pkg::CMD_BITS-1:0] cmd,
                                          input logic [ios_pkg::POS_BITS-1:0] pos,
                                          input logic [ios_pkg::TYPE_BITS-1:0] tag,
                                          input logic [ios_pkg::VALUE_BITS-1:0] value,
                                          input logic clr);
    stack_req_t rq;
    rq.cmd   = cmd;
    rq.pos   = pos;
    rq.tag   = tag;
    rq.value = value;
    rq.clr   = clr;
    return rq;
  endfunction

  function automatic logic [ios_pkg::VALUE_BITS-1:0] random_value();
    logic [ios_pkg::VALUE_BITS-1:0] v;
    case ($urandom_range(0, 15))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic stack_reply_t predict_reply(input stack_req_t rq);
    stack_reply_t rp;
    int unsigned  slot;
    int unsigned  k;
    bit           hit;
    rp  = '0;
    hit = 1'b0;
    if (rq.clr) begin
      stack_fill = 0;
    end else begin
      case (rq.cmd)
        ios_pkg::CMD_PUSH: begin
          if (rq.tag == '0) begin
            rp.status = ios_pkg::ST_INVALID;
          end else if (stack_fill >= STACK_DEPTH) begin
            rp.status = ios_pkg::ST_FULL;
          end else begin
            stack_tag[stack_fill] = rq.tag;
            stack_val[stack_fill] = rq.value;
            stack_fill++;
            rp.status = ios_pkg::ST_OK;
          end
        end
        ios_pkg::CMD_POP: begin
          if (stack_fill == 0) begin
            rp.status = ios_pkg::ST_RANGE;
          end else begin
            stack_fill--;
            rp.status = ios_pkg::ST_OK;
            rp.rtype  = stack_tag[stack_fill];
            rp.rvalue = stack_val[stack_fill];
          end
        end
        ios_pkg::CMD_FETCH_TD, ios_pkg::CMD_REPL_TD,
        ios_pkg::CMD_FETCH_BU, ios_pkg::CMD_REPL_BU: begin
          if (rq.pos >= stack_fill) begin
            rp.status = ios_pkg::ST_RANGE;
          end else begin
            slot = (rq.cmd == ios_pkg::CMD_FETCH_TD || rq.cmd == ios_pkg::CMD_REPL_TD) ?
                   stack_fill - 1 - rq.pos : rq.pos;
            rp.status = ios_pkg::ST_OK;
            if (rq.cmd == ios_pkg::CMD_FETCH_TD || rq.cmd == ios_pkg::CMD_FETCH_BU) begin
              rp.rtype  = stack_tag[slot];
              rp.rvalue = stack_val[slot];
            end else begin
              stack_tag[slot] = rq.tag;
              stack_val[slot] = rq.value;
            end
          end
        end
        ios_pkg::CMD_FIND: begin
          rp.status = ios_pkg::ST_NOTFOUND;
          for (k = 0; k < stack_fill && !hit; k++) begin
            slot = stack_fill - 1 - k;
            if (stack_tag[slot] == rq.tag) begin
              hit       = 1'b1;
              rp.status = ios_pkg::ST_OK;
              rp.rtype  = stack_tag[slot];
              rp.rvalue = stack_val[slot];
              rp.fpos   = k[ios_pkg::POS_BITS-1:0];
            end
          end
        end
        default: rp.status = ios_pkg::ST_OK;
      endcase
    end
    rp.depth = stack_fill[ios_pkg::DEPTH_BITS-1:0];
    return rp;
  endfunction

  function automatic stack_req_t random_request();
    stack_req_t  rq;
    int unsigned pick;
    pick     = $urandom_range(0, 99);
    rq.clr   = 1'b0;
    rq.value = random_value();
    if (pick < 28)      rq.cmd = ios_pkg::CMD_PUSH;
    else if (pick < 46) rq.cmd = ios_pkg::CMD_POP;
    else if (pick < 55) rq.cmd = ios_pkg::CMD_FETCH_TD;
    else if (pick < 64) rq.cmd = ios_pkg::CMD_FETCH_BU;
    else if (pick < 71) rq.cmd = ios_pkg::CMD_REPL_TD;
    else if (pick < 78) rq.cmd = ios_pkg::CMD_REPL_BU;
    else if (pick < 96) rq.cmd = ios_pkg::CMD_FIND;
    else if (pick < 99) rq.cmd = CMD_UNUSED;
    else begin
      rq.cmd = ios_pkg::CMD_BITS'($urandom_range(0, 7));
      rq.clr = 1'b1;
    end
    if (stack_fill > 0 && $urandom_range(0, 3) != 0)
      rq.pos = ios_pkg::POS_BITS'($urandom_range(0, stack_fill - 1));
    else
      rq.pos = ios_pkg::POS_BITS'($urandom_range(0, 255));
    pick = $urandom_range(0, 19);
    if (pick < 14)      rq.tag = ios_pkg::TYPE_BITS'($urandom_range(1, 8));
    else if (pick < 19) rq.tag = ios_pkg::TYPE_BITS'($urandom_range(0, 31));
    else                rq.tag = '0;
    return rq;
  endfunction

  // offer one request, then maybe pause the sender between bursts
  task automatic issue(input stack_req_t rq, input bit typed, input stack_reply_t typed_reply);
    stack_reply_t rp;
    int unsigned  gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {rq.value, rq.tag, rq.pos, rq.cmd};
    in_tuser  <= rq.clr;
    do @(posedge clk); while (!in_tready);
    rp = predict_reply(rq);
    pending_replies.push_back(typed ? typed_reply : rp);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // fill from empty to the top, probe the extremes, then empty again
  task automatic fill_and_probe();
    issue(make_req(ios_pkg::CMD_PUSH, '0, '0, '0, 1'b1), 1'b0, '0);
    issue(make_req(ios_pkg::CMD_PUSH, '0, 5'd31, random_value(), 1'b0), 1'b0, '0);
    while (stack_fill < STACK_DEPTH)
      issue(make_req(ios_pkg::CMD_PUSH, ios_pkg::POS_BITS'($urandom),
                     ios_pkg::TYPE_BITS'($urandom_range(1, 30)),
                     random_value(), 1'b0), 1'b0, '0);
    issue(make_req(ios_pkg::CMD_PUSH, '0, ios_pkg::TYPE_BITS'($urandom_range(1, 31)),
                   random_value(), 1'b0), 1'b0, '0);
    issue(make_req(ios_pkg::CMD_PUSH, '0, '0, random_value(), 1'b0), 1'b0, '0);
    issue(make_req(ios_pkg::CMD_FIND, '0, 5'd31, '0, 1'b0), 1'b0, '0);
    issue(make_req(ios_pkg::CMD_FETCH_TD, 8'd255, '0, '0, 1'b0), 1'b0, '0);
    issue(make_req(ios_pkg::CMD_FETCH_BU, 8'd255, '0, '0, 1'b0), 1'b0, '0);
    issue(make_req(ios_pkg::CMD_REPL_TD, 8'd255, 5'd31, random_value(), 1'b0), 1'b0, '0);
    issue(make_req(ios_pkg::CMD_FIND, '0, ios_pkg::TYPE_BITS'($urandom_range(0, 31)), '0,
                   1'b0), 1'b0, '0);
    repeat (3) issue(make_req(ios_pkg::CMD_POP, '0, '0, '0, 1'b0), 1'b0, '0);
    issue(make_req(ios_pkg::CMD_FIND, '0, 5'd31, '0, 1'b0), 1'b0, '0);
    issue(make_req(CMD_UNUSED, '0, '0, '0, 1'b1), 1'b0, '0);
  endtask

  task automatic check_reply(input logic [95:0] word);
    stack_reply_t want;
    stack_reply_t got;
    got.status = word[2:0];
    got.rtype  = word[7:3];
    got.rvalue = word[71:8];
    got.fpos   = word[79:72];
    got.depth  = word[88:80];
    if (pending_replies.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result %h with no request pending", word);
    end else begin
      want = pending_replies.pop_front();
      if (got !== want || word[95:89] !== '0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: st %0d/%0d type %0d/%0d val %h/%h pos %0d/%0d dep %0d/%0d pad %h",
                   want.status, got.status, want.rtype, got.rtype, want.rvalue, got.rvalue,
                   want.fpos, got.fpos, want.depth, got.depth, word[95:89]);
      end
    end
  endtask

  initial begin : result_side
    int unsigned phase_left;
    int unsigned stall_pct;
    bit          held;
    phase_left = 0;
    stall_pct  = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        check_reply(out_tdata);
        replies_seen++;
      end
      if (!held && replies_seen >= 300) begin
        // long hold-off so the core backs up into its input
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(1, 40);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 30;
            3:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        phase_left--;
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : request_side
    stack_reply_t typed_reply;
    table_row_t   row;
    int unsigned  sent;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      row                = DIRECTED_ROWS[i];
      typed_reply        = '0;
      typed_reply.status = row.status;
      typed_reply.depth  = row.depth;
      issue(make_req(row.cmd, row.pos, row.tag, row.value, row.clr), row.typed, typed_reply);
    end

    fill_and_probe();
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == RANDOM_ITEMS / 2) fill_and_probe();
      issue(random_request(), 1'b0, '0);
      sent++;
    end
    in_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ios_pkg.sv
rtl/core/ios_store.sv
rtl/core/ios_ctrl.sv
rtl/core/indexed_object_stack_core.sv
tb/tb_indexed_object_stack_core.sv
